### src/sm3_pkg.sv
package sm3_pkg;

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  valid_bytes;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_EXPAND,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam logic [31:0] TJ_LOW  = 32'h79cc4519;
   localparam logic [31:0] TJ_HIGH = 32'h7a879d8a;
   localparam logic [7:0]  PAD_MARK = 8'h80;

   function automatic logic [31:0] sm3_iv(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0: v = 32'h7380166f;
         3'd1: v = 32'h4914b2b9;
         3'd2: v = 32'h172442d7;
         3'd3: v = 32'hda8a0600;
         3'd4: v = 32'ha96f30bc;
         3'd5: v = 32'h163138aa;
         3'd6: v = 32'he38dee4d;
         default: v = 32'hb0fb0e4e;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
      logic [63:0] d;
      d = {x, x} << k;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

### src/sm3_round.sv
module sm3_round (
   input  logic [255:0] state_in,
   input  logic [31:0]  wj,
   input  logic [31:0]  wj4,
   input  logic [5:0]   round,
   output logic [255:0] state_out
);
   import sm3_pkg::*;

   logic [31:0] a, b, c, d, e, f, g, h;
   logic [31:0] tc, a12, ss1, ss2, ff, gg, tt1, tt2;

   always_comb begin
      {a, b, c, d, e, f, g, h} = state_in;
      tc  = (round < 6'd16) ? TJ_LOW : TJ_HIGH;
      a12 = rotl(a, 5'd12);
      ss1 = rotl(a12 + e + rotl(tc, round[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      if (round < 6'd16) begin
         ff = a ^ b ^ c;
         gg = e ^ f ^ g;
      end else begin
         ff = (a & b) | (a & c) | (b & c);
         gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (wj ^ wj4);
      tt2 = gg + h + ss1 + wj;
      state_out = {tt1, a, rotl(b, 5'd9), c, perm0(tt2), e, rotl(f, 5'd19), g};
   end

endmodule

### src/sm3_hash_core.sv
// sm3_hash_core: SM3 hash, 256-bit digest, one 32-bit message word per beat.
// A non-final word is accepted while idle; every 16th word starts a block of 52
// expansion steps, 6 operand preload steps, 64 rounds and 1 fold. Rounds run
// one per cycle; no new word is taken until the block has been folded.
// Reset (synchronous, active high) loads the IV, clears length and word count.
module sm3_hash_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sm3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sm3_pkg::rsp_type rsp_data
);
   import sm3_pkg::*;

   // expanded word memory: entries 0..15 hold the block, 16..67 the expansion
   logic [31:0] wmem [0:67];
   logic [6:0]  wr_addr;
   logic [31:0] wr_data;
   logic        wr_en;

   state_type   state_ff, state_in;
   logic [255:0] cv_ff, cv_in;
   logic [255:0] wr_ff, wr_in;
   logic [3:0]  cnt_ff, cnt_in;        // words in current block
   logic [63:0] len_ff, len_in;
   logic [6:0]  step_ff, step_in;      // expansion index / round index
   logic [1:0]  pad_ff, pad_in;        // pad phase: 1 zeros, 2 length high written, 0 closed
   logic        fin_ff, fin_in;        // message closing in progress
   logic        mark_ff, mark_in;      // a full final word still owes the marker word
   logic [2:0]  oidx_ff, oidx_in;

   // expansion window: shift line of the last 16 words, fed from memory writes
   logic [31:0] win_ff [0:15];
   logic [31:0] win_in [0:15];
   logic [31:0] newx;

   // round operand registers: W[j] and W[j+4] from a 5-deep window
   logic [31:0] rw_ff [0:4];
   logic [31:0] rw_in [0:4];
   logic [31:0] rd_ff;
   logic [6:0]  rd_addr;
   logic [255:0] rnd_out;
   logic [6:0]  rnd_idx;               // round number, six steps behind the step count

   assign rnd_idx = step_ff - 7'd6;

   sm3_round u_round (
      .state_in (wr_ff),
      .wj       (rw_ff[0]),
      .wj4      (rw_ff[4]),
      .round    (rnd_idx[5:0]),
      .state_out(rnd_out)
   );

   always_ff @(posedge clock) begin
      if (wr_en) wmem[wr_addr] <= wr_data;
      rd_ff <= wmem[rd_addr];
   end

   always_comb begin
      newx = perm1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 5'd15))
           ^ rotl(win_ff[3], 5'd7) ^ win_ff[10];
   end

   // message word after masking and marker insertion
   logic [2:0]  vb;
   logic [31:0] mask, fword;
   always_comb begin
      vb = (req_data.valid_bytes > 3'd4) ? 3'd4 : req_data.valid_bytes;
      case (vb)
         3'd0: mask = 32'h0;
         3'd1: mask = 32'hff000000;
         3'd2: mask = 32'hffff0000;
         3'd3: mask = 32'hffffff00;
         default: mask = 32'hffffffff;
      endcase
      fword = req_data.message_word & mask;
      if (vb != 3'd4) fword = fword | ({24'h0, PAD_MARK} << (5'd24 - {vb[1:0], 3'b000}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         len_ff   <= '0;
         fin_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         pad_ff   <= '0;
         oidx_ff  <= '0;
         step_ff  <= '0;
         for (int i = 0; i < 8; i++) cv_ff[255-32*i -: 32] <= sm3_iv(3'(i));
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         fin_ff   <= fin_in;
         mark_ff  <= mark_in;
         pad_ff   <= pad_in;
         oidx_ff  <= oidx_in;
         step_ff  <= step_in;
         cv_ff    <= cv_in;
      end
      wr_ff <= wr_in;
      for (int i = 0; i < 16; i++) win_ff[i] <= win_in[i];
      for (int i = 0; i < 5; i++) rw_ff[i] <= rw_in[i];
   end

   // push of one block word, shared by input and padding
   logic        push;
   logic [31:0] push_word;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      fin_in   = fin_ff;
      mark_in  = mark_ff;
      pad_in   = pad_ff;
      oidx_in  = oidx_ff;
      step_in  = step_ff;
      cv_in    = cv_ff;
      wr_in    = wr_ff;
      for (int i = 0; i < 16; i++) win_in[i] = win_ff[i];
      for (int i = 0; i < 5; i++) rw_in[i] = rw_ff[i];
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_data  = '0;
      push      = 1'b0;
      push_word = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_addr   = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               push = 1'b1;
               if (!req_data.final_word) begin
                  push_word = req_data.message_word;
                  len_in    = len_ff + 64'd32;
               end else begin
                  push_word = fword;
                  len_in    = len_ff + {58'd0, vb, 3'b000};
                  fin_in    = 1'b1;
                  mark_in   = (vb == 3'd4);
                  pad_in    = 2'd1;
               end
            end
         end
         ST_PAD: begin
            // close the message one word per cycle; a marker in slot 14 or 15
            // pushes the length into a second block
            push = 1'b1;
            if (mark_ff) begin
               push_word = 32'h80000000;
               mark_in   = 1'b0;
            end else if (cnt_ff < 4'd14) begin
               push_word = '0;
            end else if (cnt_ff == 4'd14) begin
               push_word = len_ff[63:32];
               pad_in    = 2'd2;
            end else if (pad_ff == 2'd2) begin
               push_word = len_ff[31:0];
               pad_in    = 2'd0;
            end else begin
               push_word = '0;
            end
         end
         ST_EXPAND: begin
            // derive W[16..67] from the window, one per cycle
            wr_en   = 1'b1;
            wr_addr = step_ff;
            wr_data = newx;
            for (int i = 0; i < 15; i++) win_in[i] = win_ff[i+1];
            win_in[15] = newx;
            rd_addr = 7'd0;
            if (step_ff == 7'd67) begin
               step_in  = '0;
               state_in = ST_ROUND;
               wr_in    = cv_ff;
            end else begin
               step_in = step_ff + 7'd1;
            end
         end
         ST_ROUND: begin
            // step 0..5 preload the operand window, then one round a cycle
            rd_addr = (step_ff < 7'd68) ? step_ff : 7'd0;
            for (int i = 0; i < 4; i++) rw_in[i] = rw_ff[i+1];
            rw_in[4] = rd_ff;
            step_in  = step_ff + 7'd1;
            if (step_ff >= 7'd6) begin
               wr_in = rnd_out;
            end
            if (step_ff == 7'd69) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cv_in  = cv_ff ^ wr_ff;
            cnt_in = '0;
            if (fin_ff && pad_ff == 2'd0 && !mark_ff) begin
               state_in = ST_EMIT;
               oidx_in  = '0;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_valid             = 1'b1;
            rsp_data.digest_word  = cv_ff[255 - 32*oidx_ff -: 32];
            rsp_data.digest_index = oidx_ff;
            rsp_data.digest_last  = (oidx_ff == 3'd7);
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  fin_in   = 1'b0;
                  len_in   = '0;
                  for (int i = 0; i < 8; i++) cv_in[255-32*i -: 32] = sm3_iv(3'(i));
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // common word push: write memory, fill window, start block on 16th, enter padding after a final word
      if (push) begin
         wr_en   = 1'b1;
         wr_addr = {3'd0, cnt_ff};
         wr_data = push_word;
         for (int i = 0; i < 15; i++) win_in[i] = win_ff[i+1];
         win_in[15] = push_word;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            state_in = ST_EXPAND;
            step_in  = 7'd16;
         end else if (state_ff == ST_IDLE && req_data.final_word) begin
            state_in = ST_PAD;
         end else if (state_ff == ST_PAD && pad_in == 2'd0) begin
            state_in = ST_EXPAND;
         end
      end
   end

   // operand window lines up: at step s>=6, rw[0] holds W[s-6]
   // no item is taken while a block is in flight
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("req_ready outside idle");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("digest beat dropped");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.digest_last |=> state_ff == ST_IDLE && len_ff == 64'd0)
      else $error("no restart after digest");

endmodule
